// File: sv/mrv_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the request validator.
package mrv_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS     = 2'd0,
    CFG_REGISTER_COUNT  = 2'd1,
    CFG_MIN_FRAME_BYTES = 2'd2
  } mrv_cfg_idx_t;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [15:0] register_count;
    logic [3:0]  min_frame_bytes;
  } mrv_cfg_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_BROADCAST    = 4'd1,
    ST_INCOMPLETE   = 4'd2,
    ST_NOT_FOR_US   = 4'd3,
    ST_BAD_CRC      = 4'd4,
    ST_UNSUPPORTED  = 4'd5,
    ST_BAD_LENGTH   = 4'd6,
    ST_BAD_QUANTITY = 4'd7,
    ST_BAD_REGISTER = 4'd8
  } mrv_status_t;

  localparam logic [7:0]  OWN_ADDRESS_RST     = 8'd1;
  localparam logic [15:0] REGISTER_COUNT_RST  = 16'd64;
  localparam logic [3:0]  MIN_FRAME_BYTES_RST = 4'd4;

  localparam logic [7:0]  BROADCAST_ADDR     = 8'h00;
  localparam logic [7:0]  FC_READ_HOLDING    = 8'h03;
  localparam int          READ_REQUEST_BYTES = 8;
  localparam int          CRC_BYTES          = 2;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;

  // Reflected CRC-16 update, one byte, bit at a time.
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/mrv_cfg_regs.sv
// Configuration register file: own address, register count, minimum frame length.
module mrv_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [mrv_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mrv_pkg::CFG_DATA_W-1:0] wr_data,
  output mrv_pkg::mrv_cfg_t              cfg
);
  import mrv_pkg::*;

  mrv_cfg_t cfg_r;
  mrv_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (mrv_cfg_idx_t'(wr_index))
        CFG_OWN_ADDRESS:     cfg_nxt.own_address     = wr_data[7:0];
        CFG_REGISTER_COUNT:  cfg_nxt.register_count  = wr_data[15:0];
        CFG_MIN_FRAME_BYTES: cfg_nxt.min_frame_bytes = wr_data[3:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address     <= OWN_ADDRESS_RST;
      cfg_r.register_count  <= REGISTER_COUNT_RST;
      cfg_r.min_frame_bytes <= MIN_FRAME_BYTES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/mrv_frame_track.sv
// Per-frame state: byte count, CRC, two-byte holdback, captured header fields and the status.
module mrv_frame_track #(
  parameter int MAX_FRAME_BYTES = mrv_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 last_byte,
  input  mrv_pkg::mrv_cfg_t    cfg,
  output mrv_pkg::mrv_status_t status
);
  import mrv_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] POS_ADDR  = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_FUNC  = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_STHI  = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_STLO  = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_QTHI  = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_QTLO  = CNT_W'(5);
  localparam logic [CNT_W-1:0] N_CRC     = CNT_W'(CRC_BYTES);
  localparam logic [CNT_W-1:0] N_READREQ = CNT_W'(READ_REQUEST_BYTES);

  logic [CNT_W-1:0] count_r, count_nxt, n;
  logic [15:0]      crc_r, crc_nxt, crc_upd, rx_crc;
  logic [7:0]       held0_r, held0_nxt, held1_r, held1_nxt;
  logic [7:0]       addr_r, addr_nxt, func_r, func_nxt;
  logic [15:0]      start_r, start_nxt, qty_r, qty_nxt;
  logic [15:0]      room;

  always_comb begin
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    start_nxt = start_r;
    qty_nxt   = qty_r;
    if (step) begin
      case (count_r)
        POS_ADDR: addr_nxt         = rx_byte;
        POS_FUNC: func_nxt         = rx_byte;
        POS_STHI: start_nxt[15:8]  = rx_byte;
        POS_STLO: start_nxt[7:0]   = rx_byte;
        POS_QTHI: qty_nxt[15:8]    = rx_byte;
        POS_QTLO: qty_nxt[7:0]     = rx_byte;
        default:  addr_nxt         = addr_r;
      endcase
    end
  end

  // The two newest bytes are held back so the received CRC never gets absorbed.
  assign crc_upd = (count_r >= N_CRC) ? crc_absorb(crc_r, held0_r) : crc_r;
  assign rx_crc  = {rx_byte, held1_r};
  assign n       = (count_r < CNT_SAT) ? count_r + CNT_W'(1) : count_r;
  assign room    = cfg.register_count - start_nxt;

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    if (step) begin
      if (last_byte) begin
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
        held0_nxt = 8'h00;
        held1_nxt = 8'h00;
      end else begin
        count_nxt = n;
        crc_nxt   = crc_upd;
        held0_nxt = held1_r;
        held1_nxt = rx_byte;
      end
    end
  end

  always_comb begin
    if (n < CNT_W'(cfg.min_frame_bytes) || n < N_CRC) begin
      status = ST_INCOMPLETE;
    end else if (addr_nxt != cfg.own_address && addr_nxt != BROADCAST_ADDR) begin
      status = ST_NOT_FOR_US;
    end else if (rx_crc != crc_upd) begin
      status = ST_BAD_CRC;
    end else if (func_nxt != FC_READ_HOLDING) begin
      status = ST_UNSUPPORTED;
    end else if (n != N_READREQ) begin
      status = ST_BAD_LENGTH;
    end else if (qty_nxt == 16'd0) begin
      status = ST_BAD_QUANTITY;
    end else if (start_nxt >= cfg.register_count || qty_nxt > room) begin
      status = ST_BAD_REGISTER;
    end else if (addr_nxt == BROADCAST_ADDR) begin
      status = ST_BROADCAST;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      held0_r <= 8'h00;
      held1_r <= 8'h00;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    func_r  <= func_nxt;
    start_r <= start_nxt;
    qty_r   <= qty_nxt;
  end

`ifndef SYNTH
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> count_r == '0 && crc_r == CRC_INIT)
    else $error("frame state not restarted after last byte");
  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_SAT)
    else $error("byte count past saturation");
  a_holdback_shift: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last_byte |=> held1_r == $past(rx_byte) && held0_r == $past(held1_r))
    else $error("holdback delay did not shift");
`endif

endmodule

// File: sv/modbus_rtu_request_validator.sv
// Top level of the Modbus RTU request validator: input register, frame tracker, result register.
// Takes one frame byte per clock while input is not stalled, back to back, with no gaps needed
// between frames. Each byte is first registered in the input register, then the CRC-16/MODBUS
// byte update, header capture and status checks run combinationally into the result register,
// so a frame's status appears on out_frame_status once its last byte has been taken from the
// input register into the result register. Sustained rate is one byte per cycle, set by the
// byte-wide CRC update; a pending status only stalls input while the result register is full
// and unread (out_ready low) and the next byte to process is itself a last byte. Non-last bytes
// produce no result. Configuration writes are always accepted and should be done between frames.
module modbus_rtu_request_validator #(
  parameter int MAX_FRAME_BYTES = mrv_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     out_frame_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrv_pkg::*;

  mrv_cfg_t    cfg;
  mrv_status_t status;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       fire1;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_status_r;

  assign cfg_ready = 1'b1;

  mrv_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Non-last bytes never need the result register.
  assign fire1    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire1;

  mrv_frame_track #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire1),
    .rx_byte   (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .status    (status)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (fire1) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire1 && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_last_byte;
    end
    if (fire1 && s1_last_r) begin
      out_status_r <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_status_r;

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire1 && s1_last_r))
    else $error("result appeared without a last byte");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_status_r))
    else $error("pending status overwritten");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !fire1 |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("input register lost a byte");
`endif

endmodule
